@@ design/wavhp_pkg.sv @@
package wavhp_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    // Error codes, dense, in the order the checks are made.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_RIFF     = 3'd1;
    localparam logic [2:0] ERR_WAVE     = 3'd2;
    localparam logic [2:0] ERR_FMT      = 3'd3;
    localparam logic [2:0] ERR_NOT_PCM  = 3'd4;
    localparam logic [2:0] ERR_NOT_MONO = 3'd5;
    localparam logic [2:0] ERR_DATA_TAG = 3'd6;
    localparam logic [2:0] ERR_DEPTH    = 3'd7;

    // Chunk tags as they appear in a little-endian 32-bit word.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM      = 16'd1;
    localparam logic [15:0] ONE_CHANNEL  = 16'd1;
    localparam logic [15:0] DEPTH_BYTE   = 16'd8;
    localparam logic [15:0] DEPTH_WORD   = 16'd16;
    localparam logic [7:0]  PCM_OFFSET   = 8'd127;
    localparam logic [7:0]  PCM_TOP_BYTE = 8'd255;
    localparam logic [15:0] SAMPLE_MAX   = 16'h7FFF;

    // Header byte positions at which a field is complete.
    localparam int unsigned POS_W = 6;
    localparam logic [POS_W-1:0] POS_RIFF_END  = 6'd3;
    localparam logic [POS_W-1:0] POS_WAVE_END  = 6'd11;
    localparam logic [POS_W-1:0] POS_FMT_END   = 6'd15;
    localparam logic [POS_W-1:0] POS_FORMAT    = 6'd21;
    localparam logic [POS_W-1:0] POS_CHANNELS  = 6'd23;
    localparam logic [POS_W-1:0] POS_RATE_END  = 6'd27;
    localparam logic [POS_W-1:0] POS_DEPTH_END = 6'd35;
    localparam logic [POS_W-1:0] POS_DATA_END  = 6'd39;
    localparam logic [POS_W-1:0] POS_LAST      = 6'd43;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         error_code;
        logic [31:0]        sample_rate;
        logic [15:0]        sample_bits;
        logic [31:0]        data_bytes;
        logic signed [15:0] sample_value;
    } t_result;

endpackage

@@ design/wavhp_core.sv @@
module wavhp_core
    import wavhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_stream_byte,
    input  logic       i_file_start,
    input  logic       i_can_push,
    output logic       o_push,
    output t_result    o_res
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_REJECT = 2'd2;

    logic             r_in_vld;
    logic [7:0]       r_in_byte;
    logic             r_in_start;

    logic [POS_W-1:0] r_pos, n_pos, e_pos;
    logic [1:0]       r_phase, n_phase, e_phase;
    logic [31:0]      r_shift, n_shift, e_shift;
    logic [31:0]      r_rate, n_rate, e_rate;
    logic [15:0]      r_depth, n_depth, e_depth;
    logic [31:0]      r_size, n_size, e_size;
    logic [7:0]       r_low, n_low, e_low;
    logic             r_odd, n_odd, e_odd;

    logic [31:0]      field;
    logic [2:0]       code;
    logic             res_vld;
    logic             advance;
    t_result          res;

    assign advance = r_in_vld && i_can_push;
    assign o_stall = r_in_vld && !i_can_push;
    assign o_push  = advance && res_vld;
    assign o_res   = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= (i_valid && !o_stall) || (r_in_vld && !advance);
        end
        if (i_valid && !o_stall) begin
            r_in_byte  <= i_stream_byte;
            r_in_start <= i_file_start;
        end
    end

    // A start flag restarts the parse from the state that reset gives.
    always_comb begin
        e_pos   = r_in_start ? '0 : r_pos;
        e_phase = r_in_start ? PH_HEADER : r_phase;
        e_shift = r_in_start ? '0 : r_shift;
        e_rate  = r_in_start ? '0 : r_rate;
        e_depth = r_in_start ? '0 : r_depth;
        e_size  = r_in_start ? '0 : r_size;
        e_low   = r_in_start ? '0 : r_low;
        e_odd   = r_in_start ? 1'b0 : r_odd;
    end

    always_comb begin
        field   = {r_in_byte, e_shift[31:8]};
        code    = ERR_NONE;
        res_vld = 1'b0;
        n_pos   = e_pos;
        n_phase = e_phase;
        n_shift = e_shift;
        n_rate  = e_rate;
        n_depth = e_depth;
        n_size  = e_size;
        n_low   = e_low;
        n_odd   = e_odd;

        res.kind         = KIND_ACCEPT;
        res.error_code   = ERR_NONE;
        res.sample_rate  = e_rate;
        res.sample_bits  = e_depth;
        res.data_bytes   = e_size;
        res.sample_value = '0;

        case (e_phase)
            PH_HEADER: begin
                n_shift = field;
                n_pos   = e_pos + 1'b1;
                case (e_pos)
                    POS_RIFF_END: begin
                        if (field != TAG_RIFF) code = ERR_RIFF;
                    end
                    POS_WAVE_END: begin
                        if (field != TAG_WAVE) code = ERR_WAVE;
                    end
                    POS_FMT_END: begin
                        if (field != TAG_FMT) code = ERR_FMT;
                    end
                    POS_FORMAT: begin
                        if (field[31:16] != FMT_PCM) code = ERR_NOT_PCM;
                    end
                    POS_CHANNELS: begin
                        if (field[31:16] != ONE_CHANNEL) code = ERR_NOT_MONO;
                    end
                    POS_RATE_END: begin
                        n_rate = field;
                    end
                    POS_DEPTH_END: begin
                        n_depth = field[31:16];
                    end
                    POS_DATA_END: begin
                        if (field != TAG_DATA) code = ERR_DATA_TAG;
                    end
                    POS_LAST: begin
                        n_size         = field;
                        n_phase        = PH_DATA;
                        n_odd          = 1'b0;
                        res_vld        = 1'b1;
                        res.data_bytes = field;
                    end
                    default: begin
                    end
                endcase
                if (code != ERR_NONE) begin
                    n_phase        = PH_REJECT;
                    res_vld        = 1'b1;
                    res.kind       = KIND_REJECT;
                    res.error_code = code;
                end
            end
            PH_DATA: begin
                if (e_depth == DEPTH_BYTE) begin
                    // Offset binary to signed; the top byte would overflow and saturates.
                    res_vld  = 1'b1;
                    res.kind = KIND_SAMPLE;
                    if (r_in_byte == PCM_TOP_BYTE) begin
                        res.sample_value = SAMPLE_MAX;
                    end else begin
                        res.sample_value = {r_in_byte - PCM_OFFSET, 8'h00};
                    end
                end else if (e_depth == DEPTH_WORD) begin
                    if (!e_odd) begin
                        n_low = r_in_byte;
                        n_odd = 1'b1;
                    end else begin
                        n_odd            = 1'b0;
                        res_vld          = 1'b1;
                        res.kind         = KIND_SAMPLE;
                        res.sample_value = {r_in_byte, e_low};
                    end
                end else begin
                    res_vld        = 1'b1;
                    res.kind       = KIND_REJECT;
                    res.error_code = ERR_DEPTH;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_HEADER;
            r_shift <= '0;
            r_rate  <= '0;
            r_depth <= '0;
            r_size  <= '0;
            r_low   <= '0;
            r_odd   <= 1'b0;
        end else if (advance) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_rate  <= n_rate;
            r_depth <= n_depth;
            r_size  <= n_size;
            r_low   <= n_low;
            r_odd   <= n_odd;
        end
    end

endmodule

@@ design/wavhp_obuf.sv @@
module wavhp_obuf
    import wavhp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_can_push,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    localparam logic [1:0] DEPTH = 2'd2;

    t_result    r_buf [2];
    logic [1:0] r_count;
    logic       r_wr;
    logic       r_rd;
    logic       pop;

    // Two entries used as a ring; o_res shows the entry at the read pointer.
    assign o_can_push = (r_count != DEPTH);
    assign o_valid    = (r_count != 2'd0);
    assign o_res      = r_buf[r_rd];
    assign pop        = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
        end else begin
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
            if (i_push) r_wr <= !r_wr;
            if (pop) r_rd <= !r_rd;
        end
        if (i_push) begin
            r_buf[r_wr] <= i_res;
        end
    end

endmodule

@@ design/wav_header_parse_pcm_sample.sv @@
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_stream_byte, i_file_start
// result    out        o_valid / i_stall    o_kind, o_error_code, o_sample_rate,
//                                           o_sample_bits, o_data_bytes, o_sample_value
//
// One byte is accepted per cycle while the result buffer has room.
// Each byte passes an input register, then the header/sample decode into a two-entry
// result buffer, so the sustained rate is one byte per clock when i_stall stays low.
// Reset is synchronous, active low, and returns the parser to header byte 0.
// A stall on the result side fills the buffer, after which o_stall rises.
module wav_header_parse_pcm_sample
    import wavhp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_stream_byte,
    input  logic               i_file_start,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic [2:0]         o_error_code,
    output logic [31:0]        o_sample_rate,
    output logic [15:0]        o_sample_bits,
    output logic [31:0]        o_data_bytes,
    output logic signed [15:0] o_sample_value
);

    logic    push;
    logic    can_push;
    t_result core_res;
    t_result out_res;

    wavhp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_stream_byte(i_stream_byte),
        .i_file_start (i_file_start),
        .i_can_push   (can_push),
        .o_push       (push),
        .o_res        (core_res)
    );

    wavhp_obuf u_obuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_res     (core_res),
        .o_can_push(can_push),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res     (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_error_code   = out_res.error_code;
    assign o_sample_rate  = out_res.sample_rate;
    assign o_sample_bits  = out_res.sample_bits;
    assign o_data_bytes   = out_res.data_bytes;
    assign o_sample_value = out_res.sample_value;

endmodule

@@ design/wavhp_checker.sv @@
module wavhp_checker
    import wavhp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [1:0]         o_kind,
    input logic [2:0]         o_error_code,
    input logic signed [15:0] o_sample_value
);

    // A stalled result transaction holds its kind, error code and sample value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_error_code)
            && $stable(o_sample_value))
        else $error("result changed while stalled");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_ACCEPT |-> o_error_code == ERR_NONE
            && o_sample_value == 16'sd0)
        else $error("accepted header carries an error or a sample");

    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_REJECT |-> o_error_code != ERR_NONE
            && o_sample_value == 16'sd0)
        else $error("reject without error code or with a sample");

    a_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_kind != 2'd3
            && (o_kind != KIND_SAMPLE || o_error_code == ERR_NONE))
        else $error("bad result kind or sample with error code");

endmodule

bind wav_header_parse_pcm_sample wavhp_checker u_wavhp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_kind        (o_kind),
    .o_error_code  (o_error_code),
    .o_sample_value(o_sample_value)
);
